/* design/sle_pkg.sv */
// Package: request codes, field widths and controller state type for the list engine.
package sle_pkg;

  // Field widths of the request and result beats
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned LEN_W  = 7;

  // Request codes
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_FIND   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_PRED   = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SUCC   = 3'd6;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_INS,
    ST_INS_PUT,
    ST_DEL_HEAD,
    ST_DEL,
    ST_SCAN,
    ST_SUCC,
    ST_RESP
  } sle_state_t;

endpackage

/* design/sle_mem.sv */
// Entry store: one write port, one read port with registered read data.
module sle_mem import sle_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [VAL_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/sequential_list_engine.sv */
// Top level: ordered word list kept in a one-read one-write store, walked by a controller.
//
// An ordered list of up to DEPTH signed 32-bit words. One request beat gives one result
// beat. Every walk goes through the entry store one entry per cycle over its single read
// port (registered read data), so latency follows the entries touched: clear, append, a
// failed request or an unused code touch none; read touches one entry; insert inside the
// list and delete shift the entries from the position to the end; find and predecessor
// scan up to the first match, or the whole list with no match; successor fetches one more
// entry on a hit that has a following entry. One request is in work at a time; a new one
// is accepted while the previous result still waits in the output register.
module sequential_list_engine import sle_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [FUNC_W-1:0]       in_func,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_operand_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_ok,
  output logic signed [VAL_W-1:0] out_result_value,
  output logic [POS_W-1:0]        out_found_index,
  output logic [LEN_W-1:0]        out_used_count,
  output logic                    out_empty,
  output logic                    out_is_full
);

  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  // compare width: holds count, position and small offsets without overflow
  localparam int unsigned XW  = ((CW > LEN_W) ? CW : LEN_W) + 1;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

  sle_state_t state_r, state_nxt;

  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    wa_r, wa_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [VAL_W-1:0] prev_r, prev_nxt;
  logic             res_ok_r, res_ok_nxt;
  logic [VAL_W-1:0] res_rv_r, res_rv_nxt;
  logic [AW-1:0]    res_fi_r, res_fi_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic [VAL_W-1:0] out_rv_r, out_rv_nxt;
  logic [POS_W-1:0] out_fi_r, out_fi_nxt;
  logic [LEN_W-1:0] out_len_r, out_len_nxt;
  logic             out_empty_r, out_empty_nxt;
  logic             out_full_r, out_full_nxt;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [VAL_W-1:0] mem_wdata, mem_rdata;

  logic             in_fire, out_free;
  logic [XW-1:0]    cnt_x, pin_x, pr_x, pr1_x, wa_x, fi_x;
  logic [CW-1:0]    cnt_m1;
  logic             ins_ok, ins_app, idx_ok, ins_last;
  logic             del_more_head, del_more, scan_hit, scan_last;

  sle_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // handshake
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // widened operands for range checks
  assign cnt_x  = XW'(count_r);
  assign pin_x  = XW'(in_position);
  assign pr_x   = XW'(pos_r);
  assign pr1_x  = pr_x + XW'(1);
  assign wa_x   = XW'(wa_r);
  assign fi_x   = XW'(res_fi_r);
  assign cnt_m1 = count_r - CW'(1);

  assign ins_ok        = (cnt_x < DEPTH_X) && (pin_x <= cnt_x);
  assign ins_app       = (pin_x == cnt_x);
  assign idx_ok        = (pin_x < cnt_x);
  assign ins_last      = (wa_x == pr1_x);
  assign del_more_head = (pr1_x < cnt_x);
  assign del_more      = ((wa_x + XW'(2)) < cnt_x);
  assign scan_hit      = (mem_rdata == val_r);
  assign scan_last     = ((wa_x + XW'(1)) >= cnt_x);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_func) inside
            FN_INSERT:                 state_nxt = (ins_ok && !ins_app) ? ST_INS : ST_RESP;
            FN_DELETE:                 state_nxt = idx_ok ? ST_DEL_HEAD : ST_RESP;
            FN_READ:                   state_nxt = idx_ok ? ST_READ : ST_RESP;
            FN_FIND, FN_PRED, FN_SUCC: state_nxt = (count_r != '0) ? ST_SCAN : ST_RESP;
            default:                   state_nxt = ST_RESP;
          endcase
        end
      end
      ST_READ:     state_nxt = ST_RESP;
      ST_INS:      state_nxt = ins_last ? ST_INS_PUT : ST_INS;
      ST_INS_PUT:  state_nxt = ST_RESP;
      ST_DEL_HEAD: state_nxt = del_more_head ? ST_DEL : ST_RESP;
      ST_DEL:      state_nxt = del_more ? ST_DEL : ST_RESP;
      ST_SCAN: begin
        if (scan_hit) begin
          state_nxt = (func_r == FN_SUCC && !scan_last) ? ST_SUCC : ST_RESP;
        end else if (scan_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_SUCC:     state_nxt = ST_RESP;
      ST_RESP:     state_nxt = out_free ? ST_IDLE : ST_RESP;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath, store access and result staging
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = wa_r;
    mem_wdata  = mem_rdata;
    mem_raddr  = wa_r + AW'(1);
    count_nxt  = count_r;
    wa_nxt     = wa_r;
    func_nxt   = func_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    prev_nxt   = prev_r;
    res_ok_nxt = res_ok_r;
    res_rv_nxt = res_rv_r;
    res_fi_nxt = res_fi_r;

    out_ok_nxt    = out_ok_r;
    out_rv_nxt    = out_rv_r;
    out_fi_nxt    = out_fi_r;
    out_len_nxt   = out_len_r;
    out_empty_nxt = out_empty_r;
    out_full_nxt  = out_full_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          func_nxt   = in_func;
          pos_nxt    = in_position;
          val_nxt    = in_operand_value;
          res_ok_nxt = 1'b0;
          res_rv_nxt = '0;
          res_fi_nxt = '0;
          unique case (in_func) inside
            FN_CLEAR: begin
              count_nxt  = '0;
              res_ok_nxt = 1'b1;
            end
            FN_INSERT: begin
              if (ins_ok && ins_app) begin
                mem_we     = 1'b1;
                mem_waddr  = pin_x[AW-1:0];
                mem_wdata  = in_operand_value;
                count_nxt  = count_r + CW'(1);
                res_ok_nxt = 1'b1;
              end else begin
                // start the upward shift from the last entry
                mem_raddr = cnt_m1[AW-1:0];
                wa_nxt    = count_r[AW-1:0];
              end
            end
            FN_DELETE, FN_READ: begin
              mem_raddr = pin_x[AW-1:0];
            end
            FN_FIND, FN_PRED, FN_SUCC: begin
              mem_raddr = '0;
              wa_nxt    = '0;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        res_rv_nxt = mem_rdata;
        res_ok_nxt = 1'b1;
      end
      // entry wa-1 arrives, goes to wa; fetch wa-2
      ST_INS: begin
        mem_we    = 1'b1;
        mem_raddr = wa_r - AW'(2);
        wa_nxt    = wa_r - AW'(1);
      end
      ST_INS_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = pr_x[AW-1:0];
        mem_wdata  = val_r;
        count_nxt  = count_r + CW'(1);
        res_ok_nxt = 1'b1;
      end
      // removed word arrives; fetch the one after it
      ST_DEL_HEAD: begin
        res_rv_nxt = mem_rdata;
        res_ok_nxt = 1'b1;
        mem_raddr  = pr1_x[AW-1:0];
        wa_nxt     = pr_x[AW-1:0];
        if (!del_more_head) begin
          count_nxt = count_r - CW'(1);
        end
      end
      // entry wa+1 arrives, goes to wa; fetch wa+2
      ST_DEL: begin
        mem_we    = 1'b1;
        mem_raddr = wa_r + AW'(2);
        wa_nxt    = wa_r + AW'(1);
        if (!del_more) begin
          count_nxt = count_r - CW'(1);
        end
      end
      // entry wa arrives; prev holds entry wa-1
      ST_SCAN: begin
        prev_nxt = mem_rdata;
        wa_nxt   = wa_r + AW'(1);
        if (scan_hit) begin
          res_fi_nxt = wa_r;
          case (func_r)
            FN_FIND: res_ok_nxt = 1'b1;
            FN_PRED: begin
              if (wa_r != '0) begin
                res_ok_nxt = 1'b1;
                res_rv_nxt = prev_r;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SUCC: begin
        res_rv_nxt = mem_rdata;
        res_ok_nxt = 1'b1;
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_rv_nxt    = res_rv_r;
          out_fi_nxt    = fi_x[POS_W-1:0];
          out_len_nxt   = cnt_x[LEN_W-1:0];
          out_empty_nxt = (count_r == '0);
          out_full_nxt  = (cnt_x >= DEPTH_X);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    wa_r        <= wa_nxt;
    func_r      <= func_nxt;
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    prev_r      <= prev_nxt;
    res_ok_r    <= res_ok_nxt;
    res_rv_r    <= res_rv_nxt;
    res_fi_r    <= res_fi_nxt;
    out_ok_r    <= out_ok_nxt;
    out_rv_r    <= out_rv_nxt;
    out_fi_r    <= out_fi_nxt;
    out_len_r   <= out_len_nxt;
    out_empty_r <= out_empty_nxt;
    out_full_r  <= out_full_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_result_value = out_rv_r;
  assign out_found_index  = out_fi_r;
  assign out_used_count   = out_len_r;
  assign out_empty        = out_empty_r;
  assign out_is_full      = out_full_r;

endmodule

/* dv/tb_top.sv */
// Testbench for the sequential list engine: request driver, reply checker and list predictor.
`timescale 1ns / 100ps

module tb_top;
  import sle_pkg::*;

  localparam int LIST_DEPTH  = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int END_DRAIN   = 150;
  localparam int RANDOM_REQS = 800;

  // Spare request code; the block must answer it with a failed reply
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

  localparam logic signed [VAL_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] WORD_MIN = 32'sh8000_0000;

  // Random segment flavors
  localparam int SEG_GROW   = 0;
  localparam int SEG_SHRINK = 1;
  localparam int SEG_MIXED  = 2;
  localparam int SEG_NOISE  = 3;

  typedef struct {
    logic [FUNC_W-1:0]       fn;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] operand;
    bit                      drain_first;  // hold off until all replies are back
  } list_req_t;

  typedef struct {
    logic                    ok;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        index;
    logic [LEN_W-1:0]        length;
    logic                    empty;
    logic                    full;
  } list_reply_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid         = 1'b0;
  logic                    in_ready;
  logic [FUNC_W-1:0]       in_func          = FN_CLEAR;
  logic [POS_W-1:0]        in_position      = '0;
  logic signed [VAL_W-1:0] in_operand_value = '0;
  logic                    out_valid;
  logic                    out_ready        = 1'b0;
  logic                    out_ok;
  logic signed [VAL_W-1:0] out_result_value;
  logic [POS_W-1:0]        out_found_index;
  logic [LEN_W-1:0]        out_used_count;
  logic                    out_empty;
  logic                    out_is_full;

  sequential_list_engine #(.DEPTH(LIST_DEPTH)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_position      (in_position),
    .in_operand_value (in_operand_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ok           (out_ok),
    .out_result_value (out_result_value),
    .out_found_index  (out_found_index),
    .out_used_count   (out_used_count),
    .out_empty        (out_empty),
    .out_is_full      (out_is_full)
  );

  always #2 clk = ~clk;

  // Stimulus and predicted replies
  list_req_t   request_q[$];
  list_reply_t list_replies_q[$];

  // Predictor copy of the list
  logic signed [VAL_W-1:0] list_words [LIST_DEPTH];
  int list_len = 0;

  // Run statistics
  int mismatch_count = 0;
  int replies_seen   = 0;
  int requests_by_fn [8];
  int ok_count       = 0;
  int longest        = 0;
  int full_rejects   = 0;
  int cycle_count    = 0;

  // Generator state
  int gen_len = 0;
  int gen_total = 0;
  logic signed [VAL_W-1:0] word_pool [8];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("[%0t] MISMATCH reply %0d %s: got %h, expected %h",
             $time, replies_seen, what, got, want);
  endtask

  // Apply one accepted request to the list copy and queue its reply
  function automatic void apply_list_request(input logic [FUNC_W-1:0] fn,
                                             input logic [POS_W-1:0] pos,
                                             input logic signed [VAL_W-1:0] v);
    list_reply_t r;
    int hit;
    int p;
    r = '{default: '0};
    p = int'(pos);
    // first index holding v, if any
    hit = -1;
    for (int k = list_len - 1; k >= 0; k--)
      if (list_words[k] == v) hit = k;
    case (fn)
      FN_CLEAR: begin
        list_len = 0;
        r.ok = 1'b1;
      end
      FN_INSERT: begin
        if (list_len < LIST_DEPTH && p <= list_len) begin
          for (int k = list_len; k > p; k--) list_words[k] = list_words[k-1];
          list_words[p] = v;
          list_len++;
          r.ok = 1'b1;
        end else if (list_len == LIST_DEPTH) begin
          full_rejects++;
        end
      end
      FN_DELETE: begin
        if (p < list_len) begin
          r.value = list_words[p];
          for (int k = p; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      FN_READ: begin
        if (p < list_len) begin
          r.value = list_words[p];
          r.ok = 1'b1;
        end
      end
      FN_FIND: begin
        if (hit >= 0) begin
          r.index = hit[POS_W-1:0];
          r.ok = 1'b1;
        end
      end
      FN_PRED: begin
        if (hit > 0) begin
          r.index = hit[POS_W-1:0];
          r.value = list_words[hit-1];
          r.ok = 1'b1;
        end
      end
      FN_SUCC: begin
        if (hit >= 0) begin
          r.index = hit[POS_W-1:0];
          if (hit + 1 < list_len) begin
            r.value = list_words[hit+1];
            r.ok = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.length = list_len[LEN_W-1:0];
    r.empty  = (list_len == 0);
    r.full   = (list_len >= LIST_DEPTH);
    list_replies_q.push_back(r);
    requests_by_fn[fn]++;
    if (r.ok) ok_count++;
    if (list_len > longest) longest = list_len;
  endfunction

  // Queue a request and track the length the list will have after it
  function automatic void queue_request(input logic [FUNC_W-1:0] fn, input int pos,
                                        input logic signed [VAL_W-1:0] v,
                                        input bit drain = 1'b0);
    list_req_t q;
    q.fn = fn;
    q.pos = pos[POS_W-1:0];
    q.operand = v;
    q.drain_first = drain;
    request_q.push_back(q);
    gen_total++;
    case (fn)
      FN_CLEAR:  gen_len = 0;
      FN_INSERT: if (gen_len < LIST_DEPTH && pos <= gen_len) gen_len++;
      FN_DELETE: if (pos < gen_len) gen_len--;
      default: ;
    endcase
  endfunction

  // Mostly pool words so searches hit and duplicates show up
  function automatic logic signed [VAL_W-1:0] pick_word();
    if ($urandom_range(0, 3) != 0) return word_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic int pick_index(input int limit);
    if (limit > 0 && $urandom_range(0, 9) != 0) return $urandom_range(0, limit - 1);
    return $urandom_range(0, LIST_DEPTH - 1);
  endfunction

  // Stimulus build, reset and end of run
  initial begin
    int seg_mode;
    int seg_len;
    int roll;
    int r3;
    int pos;
    bit drain;
    logic [FUNC_W-1:0] fn;
    logic signed [VAL_W-1:0] v;

    word_pool[0] = '0;
    word_pool[1] = -32'sd1;
    word_pool[2] = WORD_MAX;
    word_pool[3] = WORD_MIN;
    for (int k = 4; k < 8; k++) word_pool[k] = $urandom;

    // Directed: empty list corners
    queue_request(FN_CLEAR,  0, '0);
    queue_request(FN_READ,   0, '0);
    queue_request(FN_DELETE, 0, '0);
    queue_request(FN_FIND,   0, '0);
    queue_request(FN_PRED,   0, '0);
    queue_request(FN_SUCC,   0, '0);
    queue_request(FN_UNUSED, 63, WORD_MAX);
    queue_request(FN_INSERT, 1, 32'sd5);       // past the end
    // build [-1, 0, max, min]
    queue_request(FN_INSERT, 0, WORD_MAX);
    queue_request(FN_INSERT, 1, WORD_MIN);     // append
    queue_request(FN_INSERT, 0, -32'sd1);      // shift all up
    queue_request(FN_INSERT, 1, '0);           // middle
    queue_request(FN_READ,   3, '0);
    queue_request(FN_READ,   4, '0);           // at length
    queue_request(FN_READ,   63, '0);
    queue_request(FN_FIND,   0, WORD_MIN);
    queue_request(FN_FIND,   0, 32'sd5);       // miss
    queue_request(FN_PRED,   0, -32'sd1);      // first entry has no predecessor
    queue_request(FN_PRED,   0, WORD_MIN);
    queue_request(FN_SUCC,   0, WORD_MIN);     // last entry has no successor
    queue_request(FN_SUCC,   0, -32'sd1);
    queue_request(FN_INSERT, 4, -32'sd1);      // duplicate; find reports first
    queue_request(FN_FIND,   0, -32'sd1);
    queue_request(FN_DELETE, 1, '0);
    queue_request(FN_DELETE, 3, '0);           // last entry
    queue_request(FN_DELETE, 5, '0);           // beyond length
    queue_request(FN_UNUSED, 0, -32'sd1);
    queue_request(FN_CLEAR,  0, '0, 1'b1);

    // Random segments: grow toward full, shrink, mixed, and raw noise
    while (gen_total < RANDOM_REQS + 28) begin
      seg_mode = $urandom_range(SEG_GROW, SEG_NOISE);
      seg_len  = (seg_mode == SEG_GROW) ? $urandom_range(60, 110) : $urandom_range(15, 60);
      drain    = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < seg_len; n++) begin
        roll = $urandom_range(0, 99);
        r3   = $urandom_range(0, 2);
        fn   = (r3 == 0) ? FN_FIND : (r3 == 1) ? FN_PRED : FN_SUCC;
        case (seg_mode)
          SEG_GROW:   if (roll < 80) fn = FN_INSERT;
                      else if (roll < 85) fn = FN_DELETE;
                      else if (roll < 90) fn = FN_READ;
          SEG_SHRINK: if (roll < 70) fn = FN_DELETE;
                      else if (roll < 80) fn = FN_INSERT;
                      else if (roll < 90) fn = FN_READ;
          SEG_MIXED:  if (roll < 2) fn = FN_CLEAR;
                      else if (roll < 30) fn = FN_INSERT;
                      else if (roll < 55) fn = FN_DELETE;
                      else if (roll < 70) fn = FN_READ;
          default:    fn = FUNC_W'($urandom_range(0, 7));
        endcase
        if (seg_mode == SEG_NOISE) begin
          pos = $urandom_range(0, LIST_DEPTH - 1);
          v   = $urandom;
        end else begin
          v = pick_word();
          if (fn == FN_INSERT) pos = pick_index(gen_len < LIST_DEPTH ? gen_len + 1 : 0);
          else pos = pick_index(gen_len);
        end
        queue_request(fn, pos, v, drain && n == 0);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || in_valid || list_replies_q.size() != 0)
      @(posedge clk);
    repeat (END_DRAIN) @(posedge clk);

    $display("%0d requests: %0d clear, %0d insert, %0d delete, %0d read, %0d find, %0d pred,",
             replies_seen, requests_by_fn[FN_CLEAR], requests_by_fn[FN_INSERT],
             requests_by_fn[FN_DELETE], requests_by_fn[FN_READ], requests_by_fn[FN_FIND],
             requests_by_fn[FN_PRED]);
    $display("%0d succ, %0d spare code; %0d succeeded, list peaked at %0d, %0d full rejects",
             requests_by_fn[FN_SUCC], requests_by_fn[FN_UNUSED], ok_count, longest,
             full_rejects);
    if (mismatch_count == 0)
      $display("sequential_list_engine test passed");
    else
      $display("sequential_list_engine test failed");
    $finish;
  end

  // Request driver
  list_req_t next_req;
  int  send_wait  = 0;
  bit  send_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_valid && in_ready)
        apply_list_request(in_func, in_position, in_operand_value);
      if (!in_valid || in_ready) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          in_valid  <= 1'b0;
        end else if (request_q.size() != 0 &&
                     !(request_q[0].drain_first && list_replies_q.size() != 0)) begin
          next_req = request_q.pop_front();
          in_func          <= next_req.fn;
          in_position      <= next_req.pos;
          in_operand_value <= next_req.operand;
          in_valid         <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_wait <= send_burst ? 0 : $urandom_range(0, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Reply checker with random back-pressure
  list_reply_t want;
  int  recv_wait  = 0;
  bit  recv_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (list_replies_q.size() == 0) begin
          report_mismatch("beat with nothing outstanding", out_result_value, '0);
        end else begin
          want = list_replies_q.pop_front();
          if (out_ok !== want.ok) report_mismatch("ok", 32'(out_ok), 32'(want.ok));
          if (out_result_value !== want.value)
            report_mismatch("result_value", out_result_value, want.value);
          if (out_found_index !== want.index)
            report_mismatch("found_index", 32'(out_found_index), 32'(want.index));
          if (out_used_count !== want.length)
            report_mismatch("used_count", 32'(out_used_count), 32'(want.length));
          if (out_empty !== want.empty)
            report_mismatch("empty", 32'(out_empty), 32'(want.empty));
          if (out_is_full !== want.full)
            report_mismatch("is_full", 32'(out_is_full), 32'(want.full));
        end
        replies_seen++;
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, 19);
      end else if (out_valid && recv_wait != 0) begin
        recv_wait--;
      end
      out_ready <= (recv_wait == 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding",
               cycle_count, list_replies_q.size());
      $display("sequential_list_engine test failed");
      $finish;
    end
  end

endmodule

/* filelist.f */
design/sle_pkg.sv
design/sle_mem.sv
design/sequential_list_engine.sv
dv/tb_top.sv
